// ===== design/mcew_pkg.sv =====
// ----------------------------------------------------------------------------
// mcew_pkg
// Shared constants, codes and types of the multi-client epoch watchdog.
// ----------------------------------------------------------------------------
package mcew_pkg;

   localparam int MAX_CLIENTS = 16;
   localparam int IDX_W       = $clog2(MAX_CLIENTS);
   localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);
   localparam int SUM_W       = IDX_W + 1;

   localparam int ACTION_W    = 3;
   localparam int TICKET_W    = 4;
   localparam int STATUS_W    = 2;
   localparam int MARK_W      = 2;
   localparam int PERIOD_W    = 32;
   localparam int LIMIT_W     = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;

   localparam logic [ACTION_W-1:0] ACT_START      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_STOP       = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REGISTER   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_UNREGISTER = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_KICK       = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_TICK       = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_TICKET   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_TICKET  = 2'd3;

   localparam logic [MARK_W-1:0]   MARK_INVALID   = 2'd3;

   localparam logic                CSR_PERIOD     = 1'b0;
   localparam logic                CSR_LIMIT      = 1'b1;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 32'd1000;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = 5'd16;

   typedef struct packed {
      logic                accepted;
      logic [TICKET_W-1:0] ticket_out;
      logic                epoch_done;
      logic                alarm;
      logic                timed_out;
      logic [STATUS_W-1:0] status;
   } result_type;

endpackage

// ===== design/mcew_req_if.sv =====
// ----------------------------------------------------------------------------
// mcew_req_if
// Request channel of the watchdog: one action and its ticket per item.
// ----------------------------------------------------------------------------
interface mcew_req_if;
   logic                          valid;
   logic                          ready;
   logic [mcew_pkg::ACTION_W-1:0] action;
   logic [mcew_pkg::TICKET_W-1:0] ticket;

   modport source (output valid, output action, output ticket, input ready);
   modport sink   (input valid, input action, input ticket, output ready);
endinterface

// ===== design/mcew_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mcew_rsp_if
// Response channel of the watchdog: one result item per request item.
// ----------------------------------------------------------------------------
interface mcew_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          accepted;
   logic [mcew_pkg::TICKET_W-1:0] ticket_out;
   logic                          epoch_done;
   logic                          alarm;
   logic                          timed_out;
   logic [mcew_pkg::STATUS_W-1:0] status;

   modport source (output valid, output accepted, output ticket_out, output epoch_done,
                   output alarm, output timed_out, output status, input ready);
   modport sink   (input valid, input accepted, input ticket_out, input epoch_done,
                   input alarm, input timed_out, input status, output ready);
endinterface

// ===== design/multi_client_epoch_watchdog.sv =====
// ----------------------------------------------------------------------------
// multi_client_epoch_watchdog
// Watchdog shared by several clients with ticketed slots and epoch kicks.
//
//   Port      Dir   Handshake          Carries
//   req_ch    in    valid/ready        action, ticket
//   rsp_ch    out   valid/ready        accepted, ticket_out, epoch_done,
//                                      alarm, timed_out, status
//   csr_*     in    APB, pready high   period_ticks (0x0), client_limit (0x4)
//
// An item passes from the input register to the result register; one item
// is taken per cycle while the result register is empty or rsp_ch is ready.
// Slot marks, free deque and counters sit in flops and update as the item
// leaves the input register. Synchronous reset clears all watchdog state to stopped.
// A stalled rsp_ch holds the result; the input register still takes one item.
// ----------------------------------------------------------------------------
module multi_client_epoch_watchdog (
   input  logic                                clock,
   input  logic                                reset,
   mcew_req_if.sink                            req_ch,
   mcew_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [mcew_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [mcew_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [mcew_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int M     = mcew_pkg::MAX_CLIENTS;
   localparam int IDX_W = mcew_pkg::IDX_W;
   localparam int CNT_W = mcew_pkg::CNT_W;
   localparam int SUM_W = mcew_pkg::SUM_W;

   // configuration
   logic [mcew_pkg::PERIOD_W-1:0] period_ff;
   logic [mcew_pkg::LIMIT_W-1:0]  limit_ff;
   logic                          csr_write;

   // pipeline
   logic                            in_valid_ff, in_valid_in;
   logic                            out_valid_ff, out_valid_in;
   logic                            advance;
   logic [mcew_pkg::ACTION_W-1:0]   action_ff;
   logic [mcew_pkg::TICKET_W-1:0]   ticket_ff;
   mcew_pkg::result_type            result_ff, result_in;

   // watchdog state
   logic [mcew_pkg::MARK_W-1:0]     slot_ff [M];
   logic [mcew_pkg::MARK_W-1:0]     slot_in [M];
   logic [IDX_W-1:0]                free_ff [M];
   logic [IDX_W-1:0]                free_in [M];
   logic                            epoch_ff, epoch_in;
   logic [CNT_W-1:0]                kicked_ff, kicked_in;
   logic [CNT_W-1:0]                clients_ff, clients_in;
   logic [IDX_W-1:0]                head_ff, head_in;
   logic [CNT_W-1:0]                fcount_ff, fcount_in;
   logic                            running_ff, running_in;
   logic [mcew_pkg::PERIOD_W-1:0]   countdown_ff, countdown_in;
   logic                            timeout_ff, timeout_in;
   logic [CNT_W-1:0]                run_ff, run_in;

   // step helpers
   logic [mcew_pkg::PERIOD_W-1:0]   load_value;
   logic [CNT_W-1:0]                lim;
   logic [SUM_W-1:0]                pos_sum;
   logic [IDX_W-1:0]                pos;
   logic [IDX_W-1:0]                head_dec;
   logic [IDX_W-1:0]                grant;
   logic                            in_range;
   logic [mcew_pkg::MARK_W-1:0]     mark;
   logic                            close;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[2])
         mcew_pkg::CSR_PERIOD: csr_prdata = period_ff;
         mcew_pkg::CSR_LIMIT:  csr_prdata = {{(mcew_pkg::CSR_DATA_W-mcew_pkg::LIMIT_W){1'b0}},
                                             limit_ff};
         default:              csr_prdata = '0;
      endcase
   end

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign load_value = (period_ff == '0) ? mcew_pkg::PERIOD_W'(1) : period_ff;
   assign lim        = (CNT_W'(limit_ff) > CNT_W'(M)) ? CNT_W'(M) : CNT_W'(limit_ff);
   assign pos_sum    = SUM_W'(head_ff) + SUM_W'(fcount_ff) - SUM_W'(1);
   assign pos        = (pos_sum >= SUM_W'(M)) ? IDX_W'(pos_sum - SUM_W'(M))
                                              : IDX_W'(pos_sum);
   assign head_dec   = (head_ff == '0) ? IDX_W'(M - 1) : head_ff - IDX_W'(1);
   assign grant      = free_ff[pos];
   assign in_range   = CNT_W'(ticket_ff) < run_ff;
   assign mark       = slot_ff[ticket_ff];

   always_comb begin
      slot_in      = slot_ff;
      free_in      = free_ff;
      epoch_in     = epoch_ff;
      kicked_in    = kicked_ff;
      clients_in   = clients_ff;
      head_in      = head_ff;
      fcount_in    = fcount_ff;
      running_in   = running_ff;
      countdown_in = countdown_ff;
      timeout_in   = timeout_ff;
      run_in       = run_ff;
      close        = 1'b0;
      result_in    = '0;
      result_in.status = mcew_pkg::ST_OK;

      if (action_ff == mcew_pkg::ACT_START) begin
         if (!running_ff) begin
            run_in = lim;
            for (int i = 0; i < M; i++) begin
               slot_in[i] = mcew_pkg::MARK_INVALID;
               free_in[i] = IDX_W'(i);
            end
            head_in            = '0;
            fcount_in          = lim;
            kicked_in          = '0;
            clients_in         = '0;
            epoch_in           = 1'b0;
            countdown_in       = load_value;
            timeout_in         = 1'b0;
            running_in         = 1'b1;
            result_in.accepted = 1'b1;
         end
      end else if (action_ff <= mcew_pkg::ACT_TICK && !running_ff) begin
         result_in.status = mcew_pkg::ST_NOT_RUNNING;
      end else begin
         case (action_ff)
            mcew_pkg::ACT_STOP: begin
               running_in = 1'b0;
            end
            mcew_pkg::ACT_REGISTER: begin
               if (fcount_ff == '0) begin
                  result_in.status = mcew_pkg::ST_NO_TICKET;
               end else begin
                  fcount_in            = fcount_ff - CNT_W'(1);
                  clients_in           = clients_ff + CNT_W'(1);
                  kicked_in            = kicked_ff + CNT_W'(1);
                  slot_in[grant]       = {1'b0, ~epoch_ff};
                  result_in.ticket_out = mcew_pkg::TICKET_W'(grant);
                  close                = 1'b1;
               end
            end
            mcew_pkg::ACT_UNREGISTER: begin
               if (!in_range || mark == mcew_pkg::MARK_INVALID ||
                   fcount_ff >= CNT_W'(M)) begin
                  result_in.status = mcew_pkg::ST_BAD_TICKET;
               end else begin
                  head_in           = head_dec;
                  free_in[head_dec] = IDX_W'(ticket_ff);
                  fcount_in         = fcount_ff + CNT_W'(1);
                  if (clients_ff != '0) begin
                     clients_in = clients_ff - CNT_W'(1);
                  end
                  slot_in[ticket_ff] = mcew_pkg::MARK_INVALID;
                  close              = 1'b1;
               end
            end
            mcew_pkg::ACT_KICK: begin
               if (!in_range) begin
                  result_in.status = mcew_pkg::ST_BAD_TICKET;
               end else begin
                  if (mark == {1'b0, epoch_ff}) begin
                     slot_in[ticket_ff] = {1'b0, ~epoch_ff};
                     kicked_in          = kicked_ff + CNT_W'(1);
                     result_in.accepted = 1'b1;
                  end
                  close = 1'b1;
               end
            end
            mcew_pkg::ACT_TICK: begin
               if (countdown_ff <= mcew_pkg::PERIOD_W'(1)) begin
                  timeout_in      = 1'b1;
                  result_in.alarm = (clients_ff != '0);
                  countdown_in    = load_value;
               end else begin
                  countdown_in = countdown_ff - mcew_pkg::PERIOD_W'(1);
               end
            end
            default: begin
            end
         endcase
      end

      if (close && kicked_in >= clients_in) begin
         epoch_in             = ~epoch_ff;
         kicked_in            = '0;
         countdown_in         = load_value;
         timeout_in           = 1'b0;
         result_in.epoch_done = 1'b1;
      end
      result_in.timed_out = timeout_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= mcew_pkg::PERIOD_RESET;
         limit_ff     <= mcew_pkg::LIMIT_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < M; i++) begin
            slot_ff[i] <= mcew_pkg::MARK_INVALID;
            free_ff[i] <= IDX_W'(i);
         end
         epoch_ff     <= 1'b0;
         kicked_ff    <= '0;
         clients_ff   <= '0;
         head_ff      <= '0;
         fcount_ff    <= '0;
         running_ff   <= 1'b0;
         countdown_ff <= '0;
         timeout_ff   <= 1'b0;
         run_ff       <= '0;
      end else begin
         if (csr_write) begin
            case (csr_paddr[2])
               mcew_pkg::CSR_PERIOD: period_ff <= csr_pwdata;
               mcew_pkg::CSR_LIMIT:  limit_ff  <= csr_pwdata[mcew_pkg::LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            slot_ff      <= slot_in;
            free_ff      <= free_in;
            epoch_ff     <= epoch_in;
            kicked_ff    <= kicked_in;
            clients_ff   <= clients_in;
            head_ff      <= head_in;
            fcount_ff    <= fcount_in;
            running_ff   <= running_in;
            countdown_ff <= countdown_in;
            timeout_ff   <= timeout_in;
            run_ff       <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         action_ff <= req_ch.action;
         ticket_ff <= req_ch.ticket;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.accepted   = result_ff.accepted;
   assign rsp_ch.ticket_out = result_ff.ticket_out;
   assign rsp_ch.epoch_done = result_ff.epoch_done;
   assign rsp_ch.alarm      = result_ff.alarm;
   assign rsp_ch.timed_out  = result_ff.timed_out;
   assign rsp_ch.status     = result_ff.status;

endmodule

// ===== test/multi_client_epoch_watchdog_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_client_epoch_watchdog_checker
// Watches the request, response and register ports of the epoch watchdog.
// Every accepted request item runs through a local copy of the watchdog
// state (tickets, slot marks, epoch, countdown) to give the response that
// is due. Each accepted response item is compared with the oldest one due.
// ----------------------------------------------------------------------------
module multi_client_epoch_watchdog_checker (
   input  logic                            clock,
   input  logic                            reset,
   mcew_req_if                             req_mon,
   mcew_rsp_if                             rsp_mon,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic                            csr_pready,
   input  logic [mcew_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mcew_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                              fail_count,
   output int                              pending
);

   import mcew_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_PERIOD = {CSR_PERIOD, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_LIMIT  = {CSR_LIMIT, 2'b00};
   localparam int                    SHOWN_MAX   = 10;

   logic [PERIOD_W-1:0] period_ticks;
   logic [LIMIT_W-1:0]  client_limit;
   logic [MARK_W-1:0]   slot_mark [MAX_CLIENTS];
   logic [TICKET_W-1:0] free_ring [MAX_CLIENTS];
   logic                epoch;
   logic                running;
   logic                timeout_flag;
   logic [PERIOD_W-1:0] countdown;
   int                  kicked;
   int                  clients;
   int                  free_head;
   int                  free_cnt;
   int                  run_tickets;
   int                  failures;
   result_type          queued_results [$];
   result_type          got;
   result_type          want;

   assign fail_count = failures;

   function automatic logic [PERIOD_W-1:0] reload_value();
      return (period_ticks == '0) ? PERIOD_W'(1) : period_ticks;
   endfunction

   function automatic void init_slots();
      for (int i = 0; i < MAX_CLIENTS; i++) begin
         slot_mark[i] = MARK_INVALID;
         free_ring[i] = TICKET_W'(i);
      end
   endfunction

   function automatic void clear_state();
      period_ticks = PERIOD_RESET;
      client_limit = LIMIT_RESET;
      init_slots();
      epoch        = 1'b0;
      kicked       = 0;
      clients      = 0;
      free_head    = 0;
      free_cnt     = 0;
      running      = 1'b0;
      countdown    = '0;
      timeout_flag = 1'b0;
      run_tickets  = 0;
   endfunction

   function automatic logic close_epoch();
      if (kicked < clients) begin
         return 1'b0;
      end
      epoch        = ~epoch;
      kicked       = 0;
      countdown    = reload_value();
      timeout_flag = 1'b0;
      return 1'b1;
   endfunction

   function automatic result_type step_watchdog(logic [ACTION_W-1:0] act,
                                                logic [TICKET_W-1:0] tk);
      result_type          r;
      int                  lim;
      int                  pos;
      logic [TICKET_W-1:0] t;
      r = '0;
      if (act == ACT_START) begin
         if (!running) begin
            lim          = (client_limit > MAX_CLIENTS) ? MAX_CLIENTS : int'(client_limit);
            run_tickets  = lim;
            init_slots();
            free_head    = 0;
            free_cnt     = lim;
            kicked       = 0;
            clients      = 0;
            epoch        = 1'b0;
            countdown    = reload_value();
            timeout_flag = 1'b0;
            running      = 1'b1;
            r.accepted   = 1'b1;
         end
      end else if (act <= ACT_TICK && !running) begin
         r.status = ST_NOT_RUNNING;
      end else if (act == ACT_STOP) begin
         running = 1'b0;
      end else if (act == ACT_REGISTER) begin
         if (free_cnt == 0) begin
            r.status = ST_NO_TICKET;
         end else begin
            pos          = (free_head + free_cnt - 1) % MAX_CLIENTS;
            t            = free_ring[pos];
            free_cnt--;
            clients++;
            kicked++;
            slot_mark[t] = {1'b0, ~epoch};
            r.ticket_out = t;
            r.epoch_done = close_epoch();
         end
      end else if (act == ACT_UNREGISTER) begin
         if (tk >= run_tickets || slot_mark[tk] == MARK_INVALID || free_cnt >= MAX_CLIENTS) begin
            r.status = ST_BAD_TICKET;
         end else begin
            free_head            = (free_head + MAX_CLIENTS - 1) % MAX_CLIENTS;
            free_ring[free_head] = tk;
            free_cnt++;
            if (clients > 0) begin
               clients--;
            end
            slot_mark[tk] = MARK_INVALID;
            r.epoch_done  = close_epoch();
         end
      end else if (act == ACT_KICK) begin
         if (tk >= run_tickets) begin
            r.status = ST_BAD_TICKET;
         end else begin
            if (slot_mark[tk] == {1'b0, epoch}) begin
               slot_mark[tk] = {1'b0, ~epoch};
               kicked++;
               r.accepted    = 1'b1;
            end
            r.epoch_done = close_epoch();
         end
      end else if (act == ACT_TICK) begin
         if (countdown <= 1) begin
            timeout_flag = 1'b1;
            r.alarm      = (clients > 0);
            countdown    = reload_value();
         end else begin
            countdown = countdown - 1'b1;
         end
      end
      r.timed_out = timeout_flag;
      return r;
   endfunction

   function automatic string show(result_type r);
      return $sformatf("accepted=%0d ticket_out=%0d epoch_done=%0d alarm=%0d timed_out=%0d status=%0d",
                       r.accepted, r.ticket_out, r.epoch_done, r.alarm, r.timed_out, r.status);
   endfunction

   task automatic note_failure(string what);
      failures++;
      if (failures <= SHOWN_MAX) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         queued_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_PERIOD) begin
               period_ticks = csr_pwdata[PERIOD_W-1:0];
            end else if (csr_paddr == ADDR_LIMIT) begin
               client_limit = csr_pwdata[LIMIT_W-1:0];
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.accepted, rsp_mon.ticket_out, rsp_mon.epoch_done,
                   rsp_mon.alarm, rsp_mon.timed_out, rsp_mon.status};
            if (queued_results.size() == 0) begin
               note_failure({"response item with no request outstanding: ", show(got)});
            end else begin
               want = queued_results.pop_front();
               if (got !== want) begin
                  note_failure({"expected ", show(want), " got ", show(got)});
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            queued_results.push_back(step_watchdog(req_mon.action, req_mon.ticket));
         end
      end
      pending <= queued_results.size();
   end

endmodule

// ===== test/multi_client_epoch_watchdog_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_client_epoch_watchdog_tb
// Drives the epoch watchdog with a directed sequence of actions and then
// phases of random client traffic, each under its own period and client
// limit, with random gaps on both channels in phases 0 to 3. The checker
// beside the block predicts and checks each response; a stall counter bounds the run.
// ----------------------------------------------------------------------------
module multi_client_epoch_watchdog_tb;

   import mcew_pkg::*;

   localparam int                    STALL_LIMIT   = 2000;
   localparam int                    PHASE_COUNT   = 6;
   localparam logic [CSR_ADDR_W-1:0] ADDR_PERIOD   = {CSR_PERIOD, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_LIMIT    = {CSR_LIMIT, 2'b00};
   localparam logic [ACTION_W-1:0]   ACT_UNUSED_LO = 3'd6;
   localparam logic [ACTION_W-1:0]   ACT_UNUSED_HI = 3'd7;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    pending;
   int                    send_idle;
   int                    recv_idle;

   mcew_req_if req_ch ();
   mcew_rsp_if rsp_ch ();

   multi_client_epoch_watchdog i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   multi_client_epoch_watchdog_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_pready  (csr_pready),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle);
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_item(input logic [ACTION_W-1:0] act, input logic [TICKET_W-1:0] tk);
      while ($urandom_range(99) < send_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.ticket <= tk;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
   endtask

   // hold off until every response item has been taken
   task automatic wait_quiet();
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending != 0);
   endtask

   function automatic logic [ACTION_W-1:0] pick_action();
      int roll;
      roll = $urandom_range(99);
      if (roll < 40) begin
         return ACT_KICK;
      end else if (roll < 62) begin
         return ACT_TICK;
      end else if (roll < 76) begin
         return ACT_REGISTER;
      end else if (roll < 88) begin
         return ACT_UNREGISTER;
      end else if (roll < 92) begin
         return ACT_START;
      end else if (roll < 96) begin
         return ACT_STOP;
      end else if (roll < 98) begin
         return ACT_UNUSED_LO;
      end else begin
         return ACT_UNUSED_HI;
      end
   endfunction

   function automatic logic [TICKET_W-1:0] pick_ticket(int span);
      if ($urandom_range(99) < 85) begin
         return TICKET_W'($urandom_range(span - 1));
      end
      return TICKET_W'($urandom_range(15));
   endfunction

   initial begin : stall_watch
      int stale;
      stale = 0;
      while (stale < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stale = 0;
         end else begin
            stale++;
         end
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [PERIOD_W-1:0] period;
      logic [LIMIT_W-1:0]  limit;
      logic [ACTION_W-1:0] act;
      logic                after_stop;
      int                  count;
      int                  span;
      send_idle      = 37;
      recv_idle      = 88;
      after_stop     = 1'b0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.action  <= ACT_START;
      req_ch.ticket  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_write(ADDR_PERIOD, 32'd2);
      csr_write(ADDR_LIMIT, 32'd2);

      // stopped: everything but start is refused, spare codes ignored
      send_item(ACT_TICK, 4'd0);
      send_item(ACT_KICK, 4'd0);
      send_item(ACT_REGISTER, 4'd0);
      send_item(ACT_UNREGISTER, 4'd0);
      send_item(ACT_STOP, 4'd0);
      send_item(ACT_UNUSED_LO, 4'd0);
      send_item(ACT_UNUSED_HI, 4'd15);
      // start twice, drain the deque, kick out of range, then kick ticket 1 again after an epoch close
      send_item(ACT_START, 4'd0);
      send_item(ACT_START, 4'd0);
      send_item(ACT_REGISTER, 4'd0);
      send_item(ACT_REGISTER, 4'd0);
      send_item(ACT_REGISTER, 4'd0);
      send_item(ACT_KICK, 4'd15);
      send_item(ACT_KICK, 4'd1);
      send_item(ACT_KICK, 4'd1);
      send_item(ACT_KICK, 4'd0);
      // expire with clients registered
      send_item(ACT_TICK, 4'd0);
      send_item(ACT_TICK, 4'd0);
      send_item(ACT_TICK, 4'd0);
      // unregister good, stale and out-of-range tickets, then kick an empty slot
      send_item(ACT_UNREGISTER, 4'd1);
      send_item(ACT_UNREGISTER, 4'd1);
      send_item(ACT_UNREGISTER, 4'd15);
      send_item(ACT_UNREGISTER, 4'd0);
      send_item(ACT_KICK, 4'd0);
      // expire with no client
      send_item(ACT_TICK, 4'd0);
      send_item(ACT_TICK, 4'd0);
      send_item(ACT_UNUSED_LO, 4'd0);
      send_item(ACT_STOP, 4'd0);
      wait_quiet();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               period = 32'd1;
               limit  = 5'd16;
               count  = 110;
            end
            1: begin
               period = 32'hFFFF_FFFF;
               limit  = 5'd1;
               count  = 110;
            end
            2: begin
               period = 32'd0;
               limit  = 5'd0;
               count  = 20;
            end
            3: begin
               period = $urandom_range(8, 1);
               limit  = LIMIT_W'($urandom_range(16, 1));
               count  = 120;
            end
            4: begin
               period = 32'd0;
               limit  = LIMIT_W'($urandom_range(16, 1));
               count  = 110;
            end
            default: begin
               period = $urandom();
               limit  = 5'd16;
               count  = 120;
            end
         endcase
         if (phase >= 4) begin
            send_idle = 0;
            recv_idle = 0;
         end else if (phase >= 2) begin
            send_idle = 88;
            recv_idle = 37;
         end else begin
            send_idle = 37;
            recv_idle = 88;
         end
         span = (limit == 0 || limit > MAX_CLIENTS) ? MAX_CLIENTS : int'(limit);
         csr_write(ADDR_PERIOD, period);
         csr_write(ADDR_LIMIT, CSR_DATA_W'(limit));
         send_item(ACT_STOP, 4'd0);
         send_item(ACT_START, 4'd0);
         after_stop = 1'b0;
         for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) == 0) begin
               wait_quiet();
            end
            act = pick_action();
            if (after_stop && $urandom_range(3) != 0) begin
               act = ACT_START;
            end
            after_stop = (act == ACT_STOP);
            send_item(act, pick_ticket(span));
         end
         wait_quiet();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
